### hw/rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, codes and header helpers of the BMP stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  localparam int WIDTH_W  = 13;   // image width and height registers
  localparam int COL_W    = 14;   // column counter, may step past the width by up to seven
  localparam int ROWB_W   = 15;   // padded bytes per row
  localparam int ISIZE_W  = ROWB_W + WIDTH_W;
  localparam int PAL_W    = 9;
  localparam int IDX_W    = 6;    // byte index inside one command
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // image modes
  localparam logic [1:0] MODE_BILEVEL   = 2'd0;
  localparam logic [1:0] MODE_PALETTE   = 2'd1;
  localparam logic [1:0] MODE_TRUECOLOR = 2'd2;
  localparam logic [1:0] MODE_ALIAS     = 2'd3;  // treated as palette mode

  // request types
  localparam logic [1:0] REQ_BEGIN   = 2'd0;
  localparam logic [1:0] REQ_PALETTE = 2'd1;
  localparam logic [1:0] REQ_PIXEL   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd3;

  localparam logic [IDX_W-1:0] HDR_LAST_PLAIN   = 6'd53;
  localparam logic [IDX_W-1:0] HDR_LAST_BILEVEL = 6'd61;

  localparam logic [31:0] PELS_PER_M = 32'd2834;
  localparam logic [31:0] INFO_SIZE  = 32'd40;

  typedef enum logic [1:0] {
    DEPTH_1,
    DEPTH_4,
    DEPTH_8,
    DEPTH_24
  } depth_t;

  typedef enum logic {
    CMD_BYTES,
    CMD_HEADER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [1:0]           ndata;
    logic [2:0]           nzero;
    logic [7:0]           d0;
    logic [7:0]           d1;
    logic [7:0]           d2;
    logic [WIDTH_W-1:0]   w;
    logic [WIDTH_W-1:0]   h;
    logic [ROWB_W-1:0]    rowb;
    depth_t               depth;
    logic                 mode0;
  } cmd_t;

  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] idx;
  } back_status_t;

  function automatic logic [31:0] depth_bits(input depth_t d);
    case (d)
      DEPTH_1:  depth_bits = 32'd1;
      DEPTH_4:  depth_bits = 32'd4;
      DEPTH_8:  depth_bits = 32'd8;
      default:  depth_bits = 32'd24;
    endcase
  endfunction

  function automatic logic [31:0] depth_colors(input depth_t d);
    case (d)
      DEPTH_1:  depth_colors = 32'd2;
      DEPTH_4:  depth_colors = 32'd16;
      DEPTH_8:  depth_colors = 32'd256;
      default:  depth_colors = 32'd0;
    endcase
  endfunction

  // 54 plus four bytes per palette entry
  function automatic logic [31:0] depth_hsize(input depth_t d);
    case (d)
      DEPTH_1:  depth_hsize = 32'd62;
      DEPTH_4:  depth_hsize = 32'd118;
      DEPTH_8:  depth_hsize = 32'd1078;
      default:  depth_hsize = 32'd54;
    endcase
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bse_front.sv
// ----------------------------------------------------------------------------
// bse_front
// Accepts request beats, keeps the row and packing state and turns each
// request that makes file bytes into one command for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_front #(
  parameter int MAX_WIDTH  = bse_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bse_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [7:0]                    index_or_byte,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic [1:0]                    image_mode,
  input  wire logic [bse_pkg::WIDTH_W-1:0]   image_width,
  input  wire logic [bse_pkg::WIDTH_W-1:0]   image_height,
  input  wire logic [bse_pkg::PAL_W-1:0]     palette_count,
  input  wire logic                          q_full,
  output logic                               push,
  output bse_pkg::cmd_t                      cmd
);
  import bse_pkg::*;

  logic [COL_W-1:0]   column_count, column_count_next;
  logic [WIDTH_W-1:0] row_count, row_count_next;
  logic [7:0]         bit_accumulator, bit_accumulator_next;
  logic [2:0]         bit_position, bit_position_next;
  logic [3:0]         nibble_hold, nibble_hold_next;
  logic [1:0]         row_byte_phase, row_byte_phase_next;
  logic [PAL_W-1:0]   palette_seen, palette_seen_next;

  logic [WIDTH_W-1:0] eff_w, eff_h;
  logic [1:0]         eff_mode;
  depth_t             depth;
  logic [17:0]        wbits;
  logic [18:0]        wbits_rnd;
  logic [7:0]         acc_or;
  logic [1:0]         pad;
  logic               has_bytes;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && has_bytes;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height == '0) begin
      eff_h = WIDTH_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = WIDTH_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
    eff_mode = (image_mode == MODE_ALIAS) ? MODE_PALETTE : image_mode;
    if (eff_mode == MODE_BILEVEL) begin
      depth = DEPTH_1;
    end else if (eff_mode == MODE_TRUECOLOR) begin
      depth = DEPTH_24;
    end else if (palette_count <= PAL_W'(2)) begin
      depth = DEPTH_1;
    end else if (palette_count <= PAL_W'(16)) begin
      depth = DEPTH_4;
    end else begin
      depth = DEPTH_8;
    end
  end

  // padded row length in bytes
  always_comb begin
    case (depth)
      DEPTH_1:  wbits = {5'b0, eff_w};
      DEPTH_4:  wbits = {3'b0, eff_w, 2'b0};
      DEPTH_8:  wbits = {2'b0, eff_w, 3'b0};
      default:  wbits = {2'b0, eff_w, 3'b0} + {1'b0, eff_w, 4'b0};
    endcase
    wbits_rnd = {1'b0, wbits} + 19'd31;
  end

  always_comb begin
    column_count_next    = column_count;
    row_count_next       = row_count;
    bit_accumulator_next = bit_accumulator;
    bit_position_next    = bit_position;
    nibble_hold_next     = nibble_hold;
    row_byte_phase_next  = row_byte_phase;
    palette_seen_next    = palette_seen;
    cmd                  = '0;
    cmd.kind             = CMD_BYTES;
    cmd.depth            = depth;
    cmd.w                = eff_w;
    cmd.h                = eff_h;
    cmd.rowb             = {wbits_rnd[17:5], 2'b00};
    cmd.mode0            = (eff_mode == MODE_BILEVEL);
    acc_or               = bit_accumulator;
    pad                  = 2'd0;
    case (req_type)
      REQ_BEGIN: begin
        column_count_next    = '0;
        row_count_next       = '0;
        bit_accumulator_next = '0;
        bit_position_next    = '0;
        nibble_hold_next     = '0;
        row_byte_phase_next  = '0;
        palette_seen_next    = '0;
        cmd.kind             = CMD_HEADER;
      end
      REQ_PALETTE: begin
        if (eff_mode == MODE_PALETTE) begin
          cmd.ndata = 2'd3;
          cmd.nzero = 3'd1;
          if (palette_seen < palette_count) begin
            cmd.d0 = blue;
            cmd.d1 = green;
            cmd.d2 = red;
          end else begin
            cmd.d0 = 8'hff;
            cmd.d1 = 8'hff;
            cmd.d2 = 8'hff;
          end
          if (palette_seen != '1) begin
            palette_seen_next = palette_seen + PAL_W'(1);
          end
        end
      end
      REQ_PIXEL: begin
        if (row_count < eff_h) begin
          case (eff_mode)
            MODE_BILEVEL: begin
              cmd.d0            = ~index_or_byte;
              cmd.ndata         = 2'd1;
              column_count_next = column_count + COL_W'(8);
            end
            MODE_TRUECOLOR: begin
              cmd.d0            = blue;
              cmd.d1            = green;
              cmd.d2            = red;
              cmd.ndata         = 2'd3;
              column_count_next = column_count + COL_W'(1);
            end
            default: begin
              column_count_next = column_count + COL_W'(1);
              case (depth)
                DEPTH_1: begin
                  acc_or = (index_or_byte != 8'd0) ?
                           (bit_accumulator | (8'h80 >> bit_position)) : bit_accumulator;
                  if (column_count_next >= {1'b0, eff_w} || bit_position == 3'd7) begin
                    cmd.d0               = acc_or;
                    cmd.ndata            = 2'd1;
                    bit_accumulator_next = '0;
                    bit_position_next    = '0;
                  end else begin
                    bit_accumulator_next = acc_or;
                    bit_position_next    = bit_position + 3'd1;
                  end
                end
                DEPTH_4: begin
                  if (!column_count[0]) begin
                    nibble_hold_next = index_or_byte[3:0];
                    if (column_count_next >= {1'b0, eff_w}) begin
                      cmd.d0    = {index_or_byte[3:0], 4'h0};
                      cmd.ndata = 2'd1;
                    end
                  end else begin
                    cmd.d0           = {nibble_hold, index_or_byte[3:0]};
                    cmd.ndata        = 2'd1;
                    nibble_hold_next = '0;
                  end
                end
                default: begin
                  cmd.d0    = index_or_byte;
                  cmd.ndata = 2'd1;
                end
              endcase
            end
          endcase
          row_byte_phase_next = row_byte_phase + cmd.ndata;
          // row complete: pad to four bytes, maybe close the image
          if (column_count_next >= {1'b0, eff_w}) begin
            pad                  = 2'd0 - row_byte_phase_next;
            cmd.nzero            = {1'b0, pad};
            row_byte_phase_next  = '0;
            column_count_next    = '0;
            bit_accumulator_next = '0;
            bit_position_next    = '0;
            nibble_hold_next     = '0;
            row_count_next       = row_count + WIDTH_W'(1);
            if (row_count_next >= eff_h) begin
              cmd.nzero = {1'b0, pad} + 3'd2;
            end
          end
        end
      end
      default: begin
      end
    endcase
    has_bytes = (cmd.kind == CMD_HEADER) || (cmd.ndata != 2'd0) || (cmd.nzero != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      bit_accumulator <= '0;
      bit_position    <= '0;
      nibble_hold     <= '0;
      row_byte_phase  <= '0;
      palette_seen    <= '0;
    end else if (accept) begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      bit_accumulator <= bit_accumulator_next;
      bit_position    <= bit_position_next;
      nibble_hold     <= nibble_hold_next;
      row_byte_phase  <= row_byte_phase_next;
      palette_seen    <= palette_seen_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bse_queue.sv
// ----------------------------------------------------------------------------
// bse_queue
// Short command queue between the request front and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire bse_pkg::cmd_t            push_cmd,
  input  wire logic                     pop,
  output bse_pkg::cmd_t                 head,
  output logic                          full,
  output logic                          empty,
  output logic [bse_pkg::QPTR_W:0]      count
);
  import bse_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bse_back.sv
// ----------------------------------------------------------------------------
// bse_back
// Byte sequencer: expands the command at the queue head into file bytes,
// one per cycle unless out_stall holds the output, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bse_pkg::cmd_t         head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       last_of_run,
  output bse_pkg::back_status_t      status
);
  import bse_pkg::*;

  logic [IDX_W-1:0]   idx;
  logic [ISIZE_W-1:0] isize;
  logic [31:0]        fsize;

  logic               advance;
  logic               emit;
  logic               is_last;
  logic [7:0]         byte_val;
  logic [3:0]         total;
  logic [IDX_W-1:0]   hoff;
  logic [31:0]        hword;
  logic [31:0]        hshift;

  assign advance = !out_valid || !out_stall;
  assign emit    = advance && head_valid;
  assign pop     = emit && is_last;
  assign status  = '{active: head_valid, idx: idx};

  always_comb begin
    total  = 4'(head.ndata) + 4'(head.nzero);
    hoff   = idx - IDX_W'(2);
    case (hoff[5:2])
      4'd0:    hword = fsize;
      4'd2:    hword = depth_hsize(head.depth);
      4'd3:    hword = INFO_SIZE;
      4'd4:    hword = 32'(head.w);
      4'd5:    hword = 32'(head.h);
      4'd6:    hword = {16'(depth_bits(head.depth)), 16'd1};
      4'd8:    hword = 32'(isize);
      4'd9:    hword = PELS_PER_M;
      4'd10:   hword = PELS_PER_M;
      4'd11:   hword = depth_colors(head.depth);
      4'd12:   hword = depth_colors(head.depth);
      4'd14:   hword = 32'h00ff_ffff;  // white entry of the bilevel palette
      default: hword = 32'd0;
    endcase
    hshift = hword >> {hoff[1:0], 3'b000};
    if (head.kind == CMD_HEADER) begin
      is_last = (idx == (head.mode0 ? HDR_LAST_BILEVEL : HDR_LAST_PLAIN));
      if (idx == IDX_W'(0)) begin
        byte_val = 8'h42;
      end else if (idx == IDX_W'(1)) begin
        byte_val = 8'h4d;
      end else begin
        byte_val = hshift[7:0];
      end
    end else begin
      is_last = (idx == IDX_W'(total) - IDX_W'(1));
      if (idx < IDX_W'(head.ndata)) begin
        case (idx[1:0])
          2'd0:    byte_val = head.d0;
          2'd1:    byte_val = head.d1;
          default: byte_val = head.d2;
        endcase
      end else begin
        byte_val = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= is_last ? '0 : idx + IDX_W'(1);
      end
    end
  end

  // image and file size worked out while the magic bytes go out
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_val;
      last_of_run <= is_last;
      if (head.kind == CMD_HEADER && idx == IDX_W'(0)) begin
        isize <= ISIZE_W'(head.rowb) * ISIZE_W'(head.h);
      end
      if (head.kind == CMD_HEADER && idx == IDX_W'(1)) begin
        fsize <= 32'(isize) + depth_hsize(head.depth) + 32'd2;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bmp_stream_encoder.sv
// ----------------------------------------------------------------------------
// bmp_stream_encoder
// Writes an uncompressed BMP file as a byte stream from header, palette and
// pixel requests.
// ----------------------------------------------------------------------------
//  channel  signals                                        handshake
//  in       req_type index_or_byte red green blue          in_valid / in_stall
//  out      out_byte last_of_run                           out_valid / out_stall
//  cfg      cfg_index cfg_data                             cfg_we
//
//  one output byte per cycle while out_stall is low; an item makes as many bytes
//  as follows: 3 for a truecolor pixel before row padding, 4 for a palette entry, 54 or 62 for a header
//  the front takes an item per cycle while the four-entry command queue has room
//  isize and file size come from a multiplier during the first two header bytes
//  reset is synchronous and clears the counters, the queue and the output stage
//  in_stall follows queue full; out_stall holds the output register
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_stream_encoder #(
  parameter int MAX_WIDTH  = bse_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bse_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [7:0]                    index_or_byte,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte,
  output logic                               last_of_run,
  input  wire logic                          cfg_we,
  input  wire logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bse_pkg::WIDTH_W-1:0]   cfg_data
);
  import bse_pkg::*;

  logic [1:0]         image_mode;
  logic [WIDTH_W-1:0] image_width;
  logic [WIDTH_W-1:0] image_height;
  logic [PAL_W-1:0]   palette_count;

  cmd_t               push_cmd;
  cmd_t               head;
  logic               q_push, q_pop, q_full, q_empty;
  logic [QPTR_W:0]    q_count;
  back_status_t       back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_mode    <= MODE_PALETTE;
      image_width   <= WIDTH_W'(1);
      image_height  <= WIDTH_W'(1);
      palette_count <= PAL_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:          image_mode    <= cfg_data[1:0];
        CFG_WIDTH:         image_width   <= cfg_data;
        CFG_HEIGHT:        image_height  <= cfg_data;
        CFG_PALETTE_COUNT: palette_count <= cfg_data[PAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bse_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .index_or_byte (index_or_byte),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .image_mode    (image_mode),
    .image_width   (image_width),
    .image_height  (image_height),
    .palette_count (palette_count),
    .q_full        (q_full),
    .push          (q_push),
    .cmd           (push_cmd)
  );

  bse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  bse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .status      (back_status)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QPTR_W + 1)'(QDEPTH))
    else $error("command queue count past its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> back_status.active)
    else $error("command popped from an empty queue");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    back_status.idx <= HDR_LAST_BILEVEL)
    else $error("byte index past the longest command");

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bmp_stream_encoder. A queue of header, palette and
// pixel requests feeds a bursty driver; each accepted request is run through
// a local encoder model that lists the file bytes it should produce, and a
// monitor behind a stalling receiver compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bse_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 230;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bmp_req_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  typedef enum {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           req_type = '0;
  logic [7:0]           index_or_byte = '0;
  logic [7:0]           red = '0;
  logic [7:0]           green = '0;
  logic [7:0]           blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 last_of_run;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0]   cfg_data = '0;

  bmp_stream_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .index_or_byte (index_or_byte),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // register copies, tracked alongside every write
  logic [1:0]  mode_reg = MODE_PALETTE;
  logic [12:0] width_reg = 13'd1;
  logic [12:0] height_reg = 13'd1;
  logic [8:0]  pal_count_reg = 9'd2;

  // encoder state copy
  logic [12:0] col_cnt = '0;
  logic [12:0] row_cnt = '0;
  logic [7:0]  acc_bits = '0;
  logic [2:0]  bit_pos = '0;
  logic [3:0]  nib_hold = '0;
  logic [1:0]  row_phase = '0;
  logic [8:0]  pal_seen = '0;

  bmp_req_t   req_pending[$];
  file_byte_t due_bytes[$];
  logic [7:0] run_q[$];

  int reqs_queued = 0;
  int reqs_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  function automatic void put8(input logic [7:0] b);
    run_q.push_back(b);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  function automatic void put_row(input logic [7:0] b);
    put8(b);
    row_phase = row_phase + 2'd1;
  endfunction

  // bytes of the file caused by one request, appended to due_bytes
  function automatic void encode_request(input bmp_req_t r);
    logic [1:0]  m;
    int unsigned w, h, bits, colors, rowb, isize, hsize;
    file_byte_t  fb;
    run_q.delete();
    m = (mode_reg == MODE_ALIAS) ? MODE_PALETTE : mode_reg;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg;
    if (m == MODE_BILEVEL) bits = 1;
    else if (m == MODE_TRUECOLOR) bits = 24;
    else if (pal_count_reg <= 2) bits = 1;
    else if (pal_count_reg <= 16) bits = 4;
    else bits = 8;

    case (r.kind)
      REQ_BEGIN: begin
        col_cnt = '0;
        row_cnt = '0;
        acc_bits = '0;
        bit_pos = '0;
        nib_hold = '0;
        row_phase = '0;
        pal_seen = '0;
        colors = (bits == 24) ? 0 : (1 << bits);
        rowb = ((w * bits + 31) >> 3) & 32'hffff_fffc;
        isize = rowb * h;
        hsize = 54 + colors * 4;
        put8(8'h42);  // 'B'
        put8(8'h4d);  // 'M'
        put32(isize + hsize + 2);
        put32(32'd0);
        put32(hsize);
        put32(INFO_SIZE);
        put32(w);
        put32(h);
        put16(16'd1);
        put16(16'(bits));
        put32(32'd0);
        put32(isize);
        put32(PELS_PER_M);
        put32(PELS_PER_M);
        put32(colors);
        put32(colors);
        if (m == MODE_BILEVEL) begin
          // fixed black and white palette
          put32(32'h0000_0000);
          put32(32'h00ff_ffff);
        end
      end
      REQ_PALETTE: begin
        if (m == MODE_PALETTE) begin
          if (pal_seen < pal_count_reg) begin
            put8(r.blue);
            put8(r.green);
            put8(r.red);
          end else begin
            put8(8'hff);
            put8(8'hff);
            put8(8'hff);
          end
          put8(8'h00);
          if (pal_seen != 9'h1ff) pal_seen = pal_seen + 9'd1;
        end
      end
      REQ_PIXEL: begin
        if (row_cnt < h) begin
          if (m == MODE_BILEVEL) begin
            put_row(~r.idx);
            col_cnt = col_cnt + 13'd8;
          end else if (m == MODE_TRUECOLOR) begin
            put_row(r.blue);
            put_row(r.green);
            put_row(r.red);
            col_cnt = col_cnt + 13'd1;
          end else if (bits == 1) begin
            if (r.idx != 0) acc_bits = acc_bits | (8'h80 >> bit_pos);
            col_cnt = col_cnt + 13'd1;
            if (col_cnt >= w || bit_pos == 3'd7) begin
              put_row(acc_bits);
              acc_bits = '0;
              bit_pos = '0;
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end else if (bits == 4) begin
            if (!col_cnt[0]) begin
              nib_hold = r.idx[3:0];
              col_cnt = col_cnt + 13'd1;
              if (col_cnt >= w) put_row({nib_hold, 4'h0});
            end else begin
              put_row({nib_hold, r.idx[3:0]});
              nib_hold = '0;
              col_cnt = col_cnt + 13'd1;
            end
          end else begin
            put_row(r.idx);
            col_cnt = col_cnt + 13'd1;
          end
          // row complete: pad to four bytes, two zeros after the last row
          if (col_cnt >= w) begin
            while (row_phase != 2'd0) put_row(8'h00);
            col_cnt = '0;
            acc_bits = '0;
            bit_pos = '0;
            nib_hold = '0;
            row_cnt = row_cnt + 13'd1;
            if (row_cnt >= h) begin
              put8(8'h00);
              put8(8'h00);
            end
          end
        end
      end
      default: ;
    endcase

    foreach (run_q[i]) begin
      fb.data = run_q[i];
      fb.last = (i == run_q.size() - 1);
      due_bytes.push_back(fb);
    end
  endfunction

  // driver: bursts of beats with random gaps
  bmp_req_t cur_req;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_request(cur_req);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          cur_req = req_pending.pop_front();
          req_type <= cur_req.kind;
          index_or_byte <= cur_req.idx;
          red <= cur_req.red;
          green <= cur_req.green;
          blue <= cur_req.blue;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  rx_style_t  rx_style = RX_FREE;
  int         style_left = 0;
  int         hold_left = 0;
  logic       hold_armed = 1'b0;
  logic       hold_used = 1'b0;
  file_byte_t due;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got byte %h last %b",
                 $time, out_byte, last_of_run);
        mismatch_count++;
      end else begin
        due = due_bytes.pop_front();
        if (out_byte !== due.data) begin
          $display("%0t: out_byte mismatch: expected %h, got %h", $time, due.data, out_byte);
          mismatch_count++;
        end
        if (last_of_run !== due.last) begin
          $display("%0t: last_of_run mismatch: expected %b, got %b",
                   $time, due.last, last_of_run);
          mismatch_count++;
        end
      end
    end

    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 160);
      end else begin
        style_left--;
      end
      case (rx_style)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, due_bytes.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [7:0] idx,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    bmp_req_t q;
    q.kind = kind;
    q.idx = idx;
    q.red = r;
    q.green = g;
    q.blue = b;
    req_pending.push_back(q);
    reqs_queued++;
  endtask

  task automatic push_pixel();
    logic [7:0] idx;
    idx = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    push_req(REQ_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // all requests taken, all bytes seen, then let zero-byte requests drain
  task automatic settle();
    while (reqs_taken != reqs_queued || due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_image(input logic [1:0] mode, input logic [12:0] w,
                           input logic [12:0] h, input logic [8:0] pal);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data <= {11'($urandom), mode};  // upper bits are don't-care
    mode_reg = mode;
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data <= w;
    width_reg = w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h;
    height_reg = h;
    @(posedge clk);
    cfg_index <= CFG_PALETTE_COUNT;
    cfg_data <= {4'($urandom), pal};
    pal_count_reg = pal;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0]  m;
    logic [12:0] w, h;
    logic [8:0]  pal;
    int unsigned ew, eh, per_row, npix, npal;
    int          random_items;
    random_items = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset registers: pixel before any begin, pixel past the image, unused type
    push_req(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
    push_req(REQ_UNUSED, 8'h5a, 8'ha5, 8'h3c, 8'hc3);
    push_req(REQ_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PALETTE, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PALETTE, 8'h01, 8'hff, 8'hff, 8'hff);
    push_req(REQ_PALETTE, 8'h02, 8'h12, 8'h34, 8'h56);  // past the count, white
    push_req(REQ_PIXEL, 8'h80, 8'h00, 8'h00, 8'h00);
    settle();

    // bilevel, width and height saturated, palette beat ignored
    set_image(MODE_BILEVEL, 13'd8191, 13'd0, 9'd0);
    push_req(REQ_BEGIN, 8'hff, 8'hff, 8'hff, 8'hff);
    push_req(REQ_PALETTE, 8'h11, 8'h22, 8'h33, 8'h44);
    push_req(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
    settle();

    // truecolor extremes, then a pixel after the last row
    set_image(MODE_TRUECOLOR, 13'd2, 13'd2, 9'd511);
    push_req(REQ_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'h00, 8'hff, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'hff, 8'h00, 8'hff, 8'h00);
    push_req(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'hff);
    push_req(REQ_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
    push_req(REQ_PIXEL, 8'h55, 8'h55, 8'h55, 8'h55);
    settle();

    // mode 3 acts as palette mode, 4-bit pixels with an odd width
    set_image(MODE_ALIAS, 13'd3, 13'd1, 9'd16);
    push_req(REQ_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PALETTE, 8'h00, 8'hff, 8'h00, 8'hff);
    push_req(REQ_PIXEL, 8'h0f, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'hf0, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'h0a, 8'h00, 8'h00, 8'h00);
    settle();

    // width shrinks in the middle of a row
    set_image(MODE_TRUECOLOR, 13'd5, 13'd1, 9'd2);
    push_req(REQ_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00);
    push_pixel();
    push_pixel();
    settle();
    set_image(MODE_TRUECOLOR, 13'd2, 13'd1, 9'd2);
    push_pixel();
    settle();

    // receiver holds off for a long stretch while the sender keeps going
    set_image(MODE_TRUECOLOR, 13'd8, 13'd4, 9'd2);
    hold_armed <= 1'b1;
    push_req(REQ_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (32) push_pixel();
    settle();

    while (random_items < RANDOM_ITEMS) begin
      m = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       w = 13'd0;
          1:       w = 13'd4096;
          2:       w = 13'($urandom_range(4097, 8191));
          default: w = 13'($urandom_range(13, 4095));
        endcase
        case ($urandom_range(0, 3))
          0:       h = 13'd0;
          1:       h = 13'd4096;
          2:       h = 13'($urandom_range(4097, 8191));
          default: h = 13'($urandom_range(5, 4095));
        endcase
      end else begin
        w = 13'($urandom_range(1, 12));
        h = 13'($urandom_range(1, 4));
      end
      case ($urandom_range(0, 3))
        0:       pal = 9'($urandom_range(0, 2));
        1:       pal = 9'($urandom_range(3, 16));
        2:       pal = 9'($urandom_range(17, 256));
        default: pal = 9'($urandom_range(257, 511));
      endcase
      set_image(m, w, h, pal);

      ew = (w == 0) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
      eh = (h == 0) ? 1 : (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
      per_row = (m == MODE_BILEVEL) ? (ew + 7) / 8 : ew;
      npix = per_row * eh;
      // big images are only started, never finished
      if (npix > 64) npix = $urandom_range(1, 24);
      else npix = npix + $urandom_range(0, 2);

      if ($urandom_range(0, 19) != 0) begin
        push_req(REQ_BEGIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_items++;
      end
      if (m == MODE_PALETTE || m == MODE_ALIAS) begin
        npal = $urandom_range(0, (pal > 18) ? 18 : pal + 2);
        repeat (npal) begin
          push_req(REQ_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          random_items++;
        end
      end
      repeat (npix) begin
        if ($urandom_range(0, 24) == 0) begin
          push_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
        end else begin
          push_pixel();
          random_items++;
        end
      end
      settle();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
